// ----- rtl/core/sis_pkg.sv -----
// Shared types and constants for the sorted interval search block.
// Used by the controller, the datapath and the top level; no dependencies.
package sis_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND_LEFT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_RIGHT = 2'd2;

    // result kinds the controller asks the datapath to post
    localparam int RES_W = 2;
    localparam logic [RES_W-1:0] RES_NONE = 2'd0;
    localparam logic [RES_W-1:0] RES_LOAD = 2'd1;
    localparam logic [RES_W-1:0] RES_MISS = 2'd2;
    localparam logic [RES_W-1:0] RES_HIT  = 2'd3;

    // APB register index (paddr bit 2 selects the register slot)
    localparam logic REG_POINT_COUNT = 1'b0;

    typedef struct packed {
        logic             load_we;
        logic             accept_query;
        logic             issue;
        logic             step;
        logic [RES_W-1:0] res_kind;
    } t_ctrl;

    typedef struct packed {
        logic few;
        logic hit;
        logic cont;
    } t_stat;

endpackage

// ----- rtl/core/sorted_interval_search.sv -----
// Top level of the sorted interval search: APB register, controller, datapath.
// Depends on sis_pkg, sis_ctrl, sis_datapath (and sis_ram below it).
//
// Usage: raise start with cmd, load_index and key while busy is low. A load
// writes one key and its result (found 0, load_index echoed) shows in the next
// cycle; busy stays low, so loads may be issued every cycle. A left or right
// query holds busy through its init and probe states and its result shows on
// the cycle after; the number of binary search probes is at most ceil(log2) of
// the points in use (10 for a full table of 1024; none with fewer than two
// points). Each probe reads two adjacent keys together from the dual-read key
// RAM, and the next probe address is picked the same cycle, so the probe loop
// sets the rate. Results appear on o_found/o_interval_index for exactly one
// cycle with o_valid; the receiver must take them then. The user must write
// point_count over APB only while the block is idle; the block does not enforce
// it. Fewer than two points makes every query miss.
module sorted_interval_search #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sis_pkg::CMD_W-1:0]          i_cmd,
    input  logic [sis_pkg::IDX_W-1:0]          i_load_index,
    input  logic signed [sis_pkg::KEY_W-1:0]   i_key,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [sis_pkg::IDX_W-1:0]          o_interval_index,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [sis_pkg::COUNT_W-1:0] r_point_count;
    sis_pkg::t_ctrl              ctrl;
    sis_pkg::t_stat              stat;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == sis_pkg::REG_POINT_COUNT);
    assign prdata  = reg_sel ? 32'(r_point_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_point_count <= pwdata[sis_pkg::COUNT_W-1:0];
        end
    end

    sis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    sis_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_point_count    (r_point_count),
        .i_cmd            (i_cmd),
        .i_load_index     (i_load_index),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_interval_index (o_interval_index)
    );

endmodule

// ----- rtl/core/sis_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/core/sis_ctrl.sv -----
// Sequencing state machine for the sorted interval search.
// Depends on sis_pkg for command codes and the control/status structs.
module sis_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [sis_pkg::CMD_W-1:0] i_cmd,
    input  sis_pkg::t_stat            i_stat,
    output sis_pkg::t_ctrl            o_ctrl,
    output logic                      busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state             = r_state;
        o_ctrl.load_we      = 1'b0;
        o_ctrl.accept_query = 1'b0;
        o_ctrl.issue        = 1'b0;
        o_ctrl.step         = 1'b0;
        o_ctrl.res_kind     = sis_pkg::RES_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd) inside
                        sis_pkg::CMD_LOAD: begin
                            o_ctrl.load_we  = 1'b1;
                            o_ctrl.res_kind = sis_pkg::RES_LOAD;
                        end
                        sis_pkg::CMD_FIND_LEFT, sis_pkg::CMD_FIND_RIGHT: begin
                            o_ctrl.accept_query = 1'b1;
                            n_state             = ST_INIT;
                        end
                        default: begin
                            o_ctrl.res_kind = sis_pkg::RES_MISS;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                if (i_stat.few) begin
                    o_ctrl.res_kind = sis_pkg::RES_MISS;
                    n_state         = ST_IDLE;
                end else begin
                    o_ctrl.issue = 1'b1;
                    n_state      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_stat.hit) begin
                    o_ctrl.res_kind = sis_pkg::RES_HIT;
                    n_state         = ST_IDLE;
                end else if (i_stat.cont) begin
                    o_ctrl.step = 1'b1;
                end else begin
                    o_ctrl.res_kind = sis_pkg::RES_MISS;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ----- rtl/core/sis_datapath.sv -----
// Key table, search bounds and result registers for the interval search.
// Depends on sis_pkg and sis_ram.
module sis_datapath #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sis_pkg::t_ctrl              i_ctrl,
    output sis_pkg::t_stat              o_stat,
    input  logic [sis_pkg::COUNT_W-1:0] i_point_count,
    input  logic [sis_pkg::CMD_W-1:0]   i_cmd,
    input  logic [sis_pkg::IDX_W-1:0]   i_load_index,
    input  logic signed [sis_pkg::KEY_W-1:0] i_key,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [sis_pkg::IDX_W-1:0]   o_interval_index
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = (AW + 1 > sis_pkg::COUNT_W) ? AW + 1 : sis_pkg::COUNT_W;

    // midpoint rounds down for left queries, up for right queries
    function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] lo,
                                             input logic [AW-1:0] hi,
                                             input logic right);
        logic [AW:0] span;
        span   = {1'b0, hi} - {1'b0, lo} + {{AW{1'b0}}, right};
        mid_of = lo + span[AW:1];
    endfunction

    logic signed [sis_pkg::KEY_W-1:0] r_x;
    logic                             r_right;
    logic                             r_few;
    logic [AW-1:0]                    r_lo;
    logic [AW-1:0]                    r_hi;
    logic [AW-1:0]                    r_mid;

    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] max_c;
    logic [CW-1:0] used;
    logic [CW-1:0] ld_ext;
    logic          ld_ok;
    logic [AW-1:0] hi0;

    logic [sis_pkg::KEY_W-1:0] rd_a;
    logic [sis_pkg::KEY_W-1:0] rd_b;
    logic signed [sis_pkg::KEY_W-1:0] key_a;
    logic signed [sis_pkg::KEY_W-1:0] key_b;
    logic          c_low;
    logic          c_high;

    // candidate bounds for the two ways the probe can go
    logic [AW-1:0] hi1;
    logic [AW-1:0] mid1;
    logic          cont1;
    logic [AW-1:0] lo2;
    logic [AW-1:0] mid2;
    logic          cont2;

    logic [AW-1:0] n_lo;
    logic [AW-1:0] n_hi;
    logic [AW-1:0] n_mid;
    logic [AW-1:0] mid_init;
    logic [AW-1:0] rd_mid;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;

    assign cnt_ext = CW'(i_point_count);
    assign max_c   = CW'(MAX_POINTS);
    assign used    = (cnt_ext > max_c) ? max_c : cnt_ext;
    assign hi0     = AW'(used - CW'(1));
    assign ld_ext  = CW'(i_load_index);
    assign ld_ok   = (ld_ext < max_c);

    assign key_a  = $signed(rd_a);
    assign key_b  = $signed(rd_b);
    assign c_low  = r_right ? (r_x <= key_a) : (r_x < key_a);
    assign c_high = r_right ? (r_x > key_b) : (r_x >= key_b);

    assign hi1   = r_right ? (r_mid - AW'(1)) : r_mid;
    assign mid1  = mid_of(r_lo, hi1, r_right);
    assign cont1 = (r_lo < hi1);
    assign lo2   = r_right ? r_mid : (r_mid + AW'(1));
    assign mid2  = mid_of(lo2, r_hi, r_right);
    assign cont2 = (lo2 < r_hi);

    assign n_lo  = c_low ? r_lo : lo2;
    assign n_hi  = c_low ? hi1 : r_hi;
    assign n_mid = c_low ? mid1 : mid2;

    assign mid_init = mid_of(r_lo, r_hi, r_right);
    assign rd_mid   = i_ctrl.issue ? mid_init : n_mid;
    // right queries probe the pair (mid-1, mid), left queries (mid, mid+1)
    assign raddr_a  = r_right ? (rd_mid - AW'(1)) : rd_mid;
    assign raddr_b  = raddr_a + AW'(1);

    assign o_stat.few  = r_few;
    assign o_stat.hit  = !c_low && !c_high;
    assign o_stat.cont = c_low ? cont1 : cont2;

    sis_ram #(
        .WIDTH (sis_pkg::KEY_W),
        .DEPTH (MAX_POINTS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (i_ctrl.load_we && ld_ok),
        .i_waddr   (AW'(i_load_index)),
        .i_wdata   (i_key),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept_query) begin
            r_x     <= i_key;
            r_right <= (i_cmd == sis_pkg::CMD_FIND_RIGHT);
            r_few   <= (used < CW'(2));
            r_lo    <= '0;
            r_hi    <= hi0;
        end
        if (i_ctrl.issue) begin
            r_mid <= mid_init;
        end
        if (i_ctrl.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_ctrl.res_kind != sis_pkg::RES_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.res_kind)
            sis_pkg::RES_LOAD: begin
                o_found          <= 1'b0;
                o_interval_index <= i_load_index;
            end
            sis_pkg::RES_HIT: begin
                o_found          <= 1'b1;
                o_interval_index <= sis_pkg::IDX_W'(r_mid);
            end
            sis_pkg::RES_MISS: begin
                o_found          <= 1'b0;
                o_interval_index <= '0;
            end
            default: begin
                o_found          <= o_found;
                o_interval_index <= o_interval_index;
            end
        endcase
    end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for sorted_interval_search: directed table, partial key fill,
// then random phases over several point counts, checked by a local predictor or typed rows.
// Depends on sis_pkg and the sorted_interval_search RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int CMD_W = sis_pkg::CMD_W;
    localparam int IDX_W = sis_pkg::IDX_W;
    localparam int KEY_W = sis_pkg::KEY_W;
    localparam logic [CMD_W-1:0] CMD_LOAD = sis_pkg::CMD_LOAD;
    localparam logic [CMD_W-1:0] CMD_FIND_LEFT = sis_pkg::CMD_FIND_LEFT;
    localparam logic [CMD_W-1:0] CMD_FIND_RIGHT = sis_pkg::CMD_FIND_RIGHT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] POINT_COUNT_ADDR = {sis_pkg::REG_POINT_COUNT, 2'b00};
    localparam int TABLE_DEPTH = 1024;
    localparam int FILL_DEPTH = 64;
    localparam int FILL_STEP_MAX = 66000000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 350;
    localparam int STALL_LIMIT = 1000;
    localparam int END_WAIT = 30;
    localparam int unsigned EXTREME_COUNTS [6] = '{2047, 1024, 0, 1, 2, 3};

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_bracket;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
        bit                      typed;
        t_bracket                want;
        int unsigned             count;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd = '0;
    logic [IDX_W-1:0]        i_load_index = '0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    o_valid;
    logic                    o_found;
    logic [IDX_W-1:0]        o_interval_index;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // predictor state; only written entries may ever be probed
    logic signed [KEY_W-1:0] key_store [0:TABLE_DEPTH-1];
    bit                      key_written [0:TABLE_DEPTH-1];
    bit                      probe_blind = 1'b0;
    int unsigned             cur_count = 0;

    t_bracket    pending_brackets[$];
    t_stim_row   directed_rows[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    bit          steady = 1'b0;

    sorted_interval_search uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_load_index     (i_load_index),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_interval_index (o_interval_index),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int used_points();
        return (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    endfunction

    // table read as the search sees it; flags a probe of a never-written entry
    function automatic logic signed [KEY_W-1:0] key_at(int i);
        if (!key_written[i]) begin
            probe_blind = 1'b1;
            return '0;
        end
        return key_store[i];
    endfunction

    // key_store[i] <= x < key_store[i+1]
    function automatic int left_bracket(logic signed [KEY_W-1:0] x);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = used_points() - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (x < key_at(mid))
                hi = mid;
            else if (x >= key_at(mid + 1))
                lo = mid + 1;
            else
                return mid;
        end
        return -1;
    endfunction

    // key_store[i-1] < x <= key_store[i]
    function automatic int right_bracket(logic signed [KEY_W-1:0] x);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = used_points() - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (x <= key_at(mid - 1))
                hi = mid - 1;
            else if (x > key_at(mid))
                lo = mid;
            else
                return mid;
        end
        return -1;
    endfunction

    // true when the search for x touches written entries only
    function automatic bit query_legal(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] x);
        probe_blind = 1'b0;
        if (cmd == CMD_FIND_LEFT)
            void'(left_bracket(x));
        else
            void'(right_bracket(x));
        return !probe_blind;
    endfunction

    function automatic t_bracket predict_bracket(logic [CMD_W-1:0] cmd,
                                                 logic [IDX_W-1:0] idx,
                                                 logic signed [KEY_W-1:0] key);
        t_bracket res;
        int hit;
        res = '0;
        hit = -1;
        case (cmd)
            CMD_LOAD: begin
                key_store[idx] = key;
                key_written[idx] = 1'b1;
                res.index = idx;
            end
            CMD_FIND_LEFT:  hit = left_bracket(key);
            CMD_FIND_RIGHT: hit = right_bracket(key);
            default: ;
        endcase
        if (hit >= 0) begin
            res.found = 1'b1;
            res.index = hit[IDX_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] key_between(longint lo, longint hi);
        if (hi < lo)
            return lo[KEY_W-1:0];
        return KEY_W'(lo + (longint'($urandom) % (hi - lo + 1)));
    endfunction

    function automatic logic signed [KEY_W-1:0] query_key();
        int n;
        int w;
        int sel;
        int j;
        n = used_points();
        w = (n < FILL_DEPTH) ? n : FILL_DEPTH;
        sel = $urandom_range(0, 99);
        if (n < 2 || sel >= 85)
            return $urandom;
        if (sel < 60) begin
            j = $urandom_range(0, w - 1);
            return key_store[j] + KEY_W'($urandom_range(0, 2)) - 1;
        end
        return key_between(key_store[0], key_store[w - 1]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_stim_row item_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                           logic [KEY_W-1:0] key);
        t_stim_row row;
        row = '{kind: ROW_ITEM, cmd: cmd, idx: idx, key: key, typed: 1'b0,
                want: '0, count: 0};
        return row;
    endfunction

    function automatic t_stim_row typed_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                            logic [KEY_W-1:0] key, logic found,
                                            logic [IDX_W-1:0] index);
        t_stim_row row;
        row = item_row(cmd, idx, key);
        row.typed = 1'b1;
        row.want = '{found: found, index: index};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(int unsigned count);
        t_stim_row row;
        row = item_row(CMD_LOAD, '0, '0);
        row.kind = ROW_CFG;
        row.count = count;
        return row;
    endfunction

    task automatic issue_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                              logic signed [KEY_W-1:0] key, bit typed, t_bracket want);
        int gap;
        t_bracket exp;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_load_index <= idx;
        i_key <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        exp = predict_bracket(cmd, idx, key);
        pending_brackets.push_back(typed ? want : exp);
    endtask

    task automatic guard_entry(int i);
        if (!key_written[i])
            issue_item(CMD_LOAD, IDX_W'(i), KEY_MAX, 1'b0, '0);
    endtask

    // top key on the outermost left and right probe paths, so queries can
    // descend into the filled region without touching empty entries
    task automatic place_guards();
        int hi;
        int mid;
        hi = used_points() - 1;
        while (hi > 0) begin
            mid = hi / 2;
            guard_entry(mid);
            hi = mid;
        end
        hi = used_points() - 1;
        while (hi > 0) begin
            mid = (hi + 1) / 2;
            guard_entry(mid - 1);
            hi = mid - 1;
        end
    endtask

    // always waits for a clock edge, so start never gets two updates in one step
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_brackets.size() != 0);
    endtask

    task automatic write_point_count(int unsigned value);
        wait_for_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= POINT_COUNT_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_count = value & 32'h7FF;
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_bracket exp;
        if (i_rst_n && o_valid) begin
            if (pending_brackets.size() == 0) begin
                $display("%0t: unexpected result found %0b index %0d", $time,
                         o_found, o_interval_index);
                mismatch_count++;
            end else begin
                exp = pending_brackets.pop_front();
                if (o_found !== exp.found) begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             exp.found, o_found);
                    mismatch_count++;
                end
                if (o_interval_index !== exp.index) begin
                    $display("%0t: interval_index expected %0d actual %0d", $time,
                             exp.index, o_interval_index);
                    mismatch_count++;
                end
            end
        end
        if ((start && !busy) || o_valid)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        longint acc;
        longint lo;
        longint hi;
        int random_items;
        int phase;
        int r;
        int tries;
        int unsigned next_count;
        logic [IDX_W-1:0] idx;
        logic [CMD_W-1:0] cmd;
        logic signed [KEY_W-1:0] key;

        // empty table, unused command, extreme keys and indexes
        directed_rows.push_back(typed_row(CMD_FIND_LEFT, 10'd0, 32'h0000_0000, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_FIND_RIGHT, 10'd5, 32'h8000_0000, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_LOAD, 10'd0, 32'h8000_0000, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_LOAD, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 10'h3FF));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd1, 32'hFFFD_0000));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd2, 32'hFFFF_0000));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd3, 32'h0000_0000));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd4, 32'h0001_0000));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd5, 32'h0002_8000));
        directed_rows.push_back(item_row(CMD_LOAD, 10'd6, 32'h0005_0000));
        directed_rows.push_back(typed_row(CMD_LOAD, 10'd7, 32'h7FFF_FFFF, 1'b0, 10'd7));
        // a single point never brackets anything
        directed_rows.push_back(cfg_row(1));
        directed_rows.push_back(typed_row(CMD_FIND_LEFT, 10'd0, 32'h0000_0000, 1'b0, 10'd0));
        directed_rows.push_back(cfg_row(8));
        directed_rows.push_back(typed_row(CMD_FIND_LEFT, 10'd0, 32'h8000_0000, 1'b1, 10'd0));
        directed_rows.push_back(typed_row(CMD_FIND_RIGHT, 10'd0, 32'h8000_0000, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_FIND_LEFT, 10'd0, 32'h7FFF_FFFF, 1'b0, 10'd0));
        directed_rows.push_back(typed_row(CMD_FIND_RIGHT, 10'd0, 32'h7FFF_FFFF, 1'b1, 10'd7));
        directed_rows.push_back(item_row(CMD_FIND_LEFT, 10'd0, 32'h0000_0000));
        directed_rows.push_back(item_row(CMD_FIND_RIGHT, 10'd0, 32'h0000_0000));
        directed_rows.push_back(item_row(CMD_FIND_LEFT, 10'd0, 32'h0002_8000));
        directed_rows.push_back(item_row(CMD_FIND_RIGHT, 10'd0, 32'h0002_8000));
        directed_rows.push_back(item_row(CMD_FIND_LEFT, 10'd0, 32'hFFFE_8000));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_point_count(row.count);
            else
                issue_item(row.cmd, row.idx, row.key, row.typed, row.want);
        end

        // fill the low entries with ascending keys (some repeated) spread over the range
        acc = -64'sd2147483648;
        for (int i = 0; i < FILL_DEPTH; i++) begin
            issue_item(CMD_LOAD, IDX_W'(i), acc[KEY_W-1:0], 1'b0, '0);
            acc += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, FILL_STEP_MAX);
        end

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase < 6)
                next_count = EXTREME_COUNTS[phase];
            else begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    next_count = $urandom_range(2, FILL_DEPTH);
                else if (r < 9)
                    next_count = $urandom_range(FILL_DEPTH + 1, 1023);
                else
                    next_count = $urandom_range(0, 1) ? 1024 : 2047;
            end
            write_point_count(next_count);
            place_guards();
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(15, 50)) begin
                r = $urandom_range(0, 99);
                idx = IDX_W'($urandom);
                if (r < 3) begin
                    wait_for_results();
                end else if (r < 15) begin
                    // mostly keep the table sorted; now and then break it
                    if ($urandom_range(0, 9) != 0)
                        idx = IDX_W'($urandom_range(0, FILL_DEPTH - 1));
                    lo = (idx > 0 && key_written[idx - 1]) ? longint'(key_store[idx - 1])
                                                            : -64'sd2147483648;
                    hi = (idx < TABLE_DEPTH - 1 && key_written[idx + 1])
                         ? longint'(key_store[idx + 1]) : 64'sd2147483647;
                    key = ($urandom_range(0, 19) == 0) ? $urandom : key_between(lo, hi);
                    issue_item(CMD_LOAD, idx, key, 1'b0, '0);
                    random_items++;
                end else if (r < 18) begin
                    issue_item(CMD_UNUSED, idx, $urandom, 1'b0, '0);
                end else begin
                    cmd = $urandom_range(0, 1) ? CMD_FIND_LEFT : CMD_FIND_RIGHT;
                    tries = 0;
                    do begin
                        key = query_key();
                        tries++;
                    end while (!query_legal(cmd, key) && tries < 8);
                    if (!query_legal(cmd, key))
                        cmd = CMD_UNUSED;
                    issue_item(cmd, idx, key, 1'b0, '0);
                    random_items++;
                end
            end
            phase++;
        end

        wait_for_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_brackets.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sis_pkg.sv
rtl/core/sis_ram.sv
rtl/core/sis_ctrl.sv
rtl/core/sis_datapath.sv
rtl/core/sorted_interval_search.sv
verif/testbench.sv
